FILE: hdl/u8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and byte classification for the UTF-8 to UTF-16
// transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPL_CHAR     = 16'hFFFD;
  localparam logic [15:0] SURR_LO       = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE = 16'hDC00;
  localparam logic [9:0]  TEN_BITS      = 10'h3FF;

  // Code point limits, 21 bits wide
  localparam logic [20:0] CP_MIN2     = 21'h000080;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] MAX_CP      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    K_ASCII,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4,
    K_CONT,
    K_BAD
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } ubyte_t;

  typedef struct packed {
    ubyte_t b;
    logic   eos;
  } item_t;

  typedef enum logic [1:0] {
    S_TAKE,
    S_RUN,
    S_LOW
  } back_state_t;

  function automatic kind_t classify(input logic [7:0] c);
    kind_t k;
    if (!c[7])                  k = K_ASCII;
    else if (c[7:5] == 3'b110)  k = K_LEAD2;
    else if (c[7:4] == 4'b1110) k = K_LEAD3;
    else if (c[7:3] == 5'b11110) k = K_LEAD4;
    else if (c[7:6] == 2'b10)   k = K_CONT;
    else                        k = K_BAD;
    return k;
  endfunction

  // Total sequence length in bytes; single-byte kinds give 1
  function automatic logic [2:0] seq_len(input kind_t k);
    logic [2:0] n;
    case (k)
      K_LEAD2: n = 3'd2;
      K_LEAD3: n = 3'd3;
      K_LEAD4: n = 3'd4;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic is_lead(input kind_t k);
    return (k == K_LEAD2) || (k == K_LEAD3) || (k == K_LEAD4);
  endfunction

  // True if a buffer with this front byte and fill will produce a unit
  function automatic logic will_emit(input kind_t k, input logic [2:0] cnt,
                                     input logic eos);
    return (cnt != 3'd0) && (!is_lead(k) || (cnt >= seq_len(k)) || eos);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out, with replacement on bad input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one UTF-8 byte per transaction
//   plus end_of_string on the last byte. Output channel (out_valid/out_ready)
//   carries one code unit per transaction; run_last marks the last unit
//   caused by an input byte, string_last the final unit of the string.
//   A byte that only extends an unfinished sequence produces no output.
//   An input byte passes the front register and the queue, is taken by
//   the decode sequencer and then decoded into the output register.
//   The sequencer takes one byte, then emits its units one at a time (or
//   moves on when the byte completes nothing) before it takes the next;
//   rescans after a malformed sequence emit one replacement per byte.
//   The front register and a 2-entry queue keep accepting input while the
//   sequencer is busy or the output is stalled.
//   Reset clears the pending byte count, queue and all valid flags; held
//   bytes are dropped. A stalled receiver holds the output register and
//   the sequencer waits, then the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        run_last,
  output logic        string_last
);
  import u8u16_pkg::*;

  // front stage to queue
  logic  f_valid;
  logic  f_ready;
  item_t f_item;

  // queue to decode sequencer
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .f_valid       (f_valid),
    .f_ready       (f_ready),
    .f_item        (f_item)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_unit   (code_unit),
    .run_last    (run_last),
    .string_last (string_last)
  );

endmodule
`default_nettype wire

FILE: hdl/u8u16_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// Input stage: registers each incoming byte with its class tag.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_string,
  output logic              f_valid,
  input  logic              f_ready,
  output u8u16_pkg::item_t  f_item
);
  import u8u16_pkg::*;

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item.b.data <= in_byte;
      f_item.b.kind <= classify(in_byte);
      f_item.eos    <= end_of_string;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/u8u16_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  u8u16_pkg::item_t  push_item,
  output logic              q_valid,
  input  logic              q_pop,
  output u8u16_pkg::item_t  q_item
);
  import u8u16_pkg::*;

  item_t       slots [QDEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;

  assign push_ready = (count != 2'(QDEPTH));
  assign q_valid    = (count != 2'd0);
  assign q_item     = slots[rd_ptr];
  assign do_push    = push && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (q_pop)   rd_ptr <= !rd_ptr;
      case ({do_push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QDEPTH))
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != 2'd0))
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (do_push && !q_pop && count == 2'd1) |=> (count == 2'd2))
    else $error("queue lost a push");

endmodule
`default_nettype wire

FILE: hdl/u8u16_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// Decode sequencer: holds pending bytes, resolves them into code units one
// sequence at a time and drives the registered output transaction.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  u8u16_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       code_unit,
  output logic              run_last,
  output logic              string_last
);
  import u8u16_pkg::*;

  back_state_t state, state_next;
  ubyte_t      pend [4];
  ubyte_t      pend_next [4];
  logic [2:0]  cnt, cnt_next;
  logic        eos, eos_next;
  logic [15:0] low_unit, low_next;

  // decode of the front sequence
  logic        lead;
  logic [2:0]  len;
  logic        complete;
  logic        conts_ok;
  logic [20:0] cp;
  logic        cp_bad;
  logic        good;
  logic        wide;
  logic [2:0]  drop;
  logic [2:0]  rest;
  logic        more;
  logic [19:0] v;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;

  logic        out_free;
  logic        emit;
  logic [15:0] unit;
  logic        last;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    lead     = is_lead(pend[0].kind);
    len      = seq_len(pend[0].kind);
    complete = (cnt >= len);
    conts_ok = 1'b1;
    for (int j = 1; j < 4; j++) begin
      if ((3'(j) < len) && (pend[j].kind != K_CONT)) conts_ok = 1'b0;
    end
    case (len)
      3'd2:    cp = {10'd0, pend[0].data[4:0], pend[1].data[5:0]};
      3'd3:    cp = {5'd0, pend[0].data[3:0], pend[1].data[5:0], pend[2].data[5:0]};
      3'd4:    cp = {pend[0].data[2:0], pend[1].data[5:0], pend[2].data[5:0],
                     pend[3].data[5:0]};
      default: cp = {13'd0, pend[0].data};
    endcase
    cp_bad = ((len == 3'd2) && (cp < CP_MIN2)) ||
             ((len == 3'd3) && (cp < CP_MIN3)) ||
             ((len == 3'd4) && (cp < SUPP_BASE)) ||
             (cp > MAX_CP) ||
             ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
    good    = lead && complete && conts_ok && !cp_bad;
    wide    = (cp >= SUPP_BASE);
    drop    = good ? len : 3'd1;
    rest    = cnt - drop;
    more    = will_emit(pend[drop[1:0]].kind, rest, eos);
    v       = 20'(cp - SUPP_BASE);
    hi_unit = SURR_LO + {6'd0, v[19:10] & TEN_BITS};
    lo_unit = LOW_SURR_BASE + {6'd0, v[9:0] & TEN_BITS};
  end

  always_comb begin
    logic [2:0] idx;
    state_next = state;
    pend_next  = pend;
    cnt_next   = cnt;
    eos_next   = eos;
    low_next   = low_unit;
    q_pop      = 1'b0;
    emit       = 1'b0;
    unit       = REPL_CHAR;
    last       = 1'b0;
    idx        = 3'd0;
    case (state)
      S_TAKE: begin
        q_pop = q_valid;
        if (q_valid) begin
          pend_next[cnt[1:0]] = q_item.b;
          cnt_next            = cnt + 3'd1;
          eos_next            = q_item.eos;
          state_next          = S_RUN;
        end
      end
      S_RUN: begin
        if (lead && !complete) begin
          if (eos) begin
            // truncated at end of string: one replacement, rest dropped
            emit = 1'b1;
            last = 1'b1;
            if (out_free) begin
              cnt_next   = 3'd0;
              state_next = S_TAKE;
            end
          end else begin
            state_next = S_TAKE;
          end
        end else begin
          emit = 1'b1;
          if (!lead)      unit = (pend[0].kind == K_ASCII) ? {8'h00, pend[0].data}
                                                           : REPL_CHAR;
          else if (!good) unit = REPL_CHAR;
          else if (wide)  unit = hi_unit;
          else            unit = cp[15:0];
          last = !(good && wide) && !more;
          if (out_free) begin
            for (int i = 0; i < 4; i++) begin
              idx = 3'(i) + drop;
              if (idx < 3'd4) pend_next[i] = pend[idx[1:0]];
            end
            cnt_next = rest;
            if (good && wide) begin
              low_next   = lo_unit;
              state_next = S_LOW;
            end else begin
              state_next = more ? S_RUN : S_TAKE;
            end
          end
        end
      end
      S_LOW: begin
        emit = 1'b1;
        unit = low_unit;
        last = !will_emit(pend[0].kind, cnt, eos);
        if (out_free) state_next = last ? S_TAKE : S_RUN;
      end
      default: state_next = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      cnt   <= 3'd0;
      eos   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      eos   <= eos_next;
    end
  end

  always_ff @(posedge clk) begin
    pend     <= pend_next;
    low_unit <= low_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      code_unit   <= unit;
      run_last    <= last;
      string_last <= last && eos;
    end
  end

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |-> (cnt <= 3'd3))
    else $error("pending buffer overfull while waiting for a byte");

  a_eos_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE && eos) |-> (cnt == 3'd0))
    else $error("bytes left pending after end of string");

  a_str_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && string_last) |-> run_last)
    else $error("string_last without run_last");

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_utf16_transcoder. A queued driver feeds
// UTF-8 bytes through the valid/ready input, and a monitor checks every
// output code unit against a cycle-free predictor of the decoder.
// ----------------------------------------------------------------------------
module tb;
  import u8u16_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       drain;    // hold this byte back until all units are in
  } feed_t;

  typedef struct packed {
    logic [15:0] code;
    logic        run_last;
    logic        string_last;
  } unit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_last;

  feed_t       feed_q[$];      // bytes waiting to be driven
  unit_t       unit_q[$];      // code units the decoder still owes us

  // Predictor state: bytes of an unfinished sequence
  logic [7:0]  held_bytes[4];
  int          held_cnt = 0;

  // Units produced by the byte being predicted
  logic [15:0] step_units[4];
  int          step_n = 0;

  int          n_bytes_in = 0;
  int          n_units_out = 0;
  int          n_strings = 0;
  int          n_errors = 0;
  int          gap_cnt = 0;
  int          hold_cnt = 0;
  bit          long_hold_done = 1'b0;

  utf8_to_utf16_transcoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_unit     (code_unit),
    .run_last      (run_last),
    .string_last   (string_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #1000000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input unit_t want);
    n_errors++;
    $display("%0t tb: %s: got %h rl=%b sl=%b, want %h rl=%b sl=%b", $realtime, what,
             code_unit, run_last, string_last, want.code, want.run_last, want.string_last);
  endtask

  function automatic void drop_held(input int k);
    if (k >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int i = 0; i < held_cnt - k; i++) held_bytes[i] = held_bytes[i + k];
      held_cnt -= k;
    end
  endfunction

  function automatic void keep_unit(input logic [15:0] u);
    if (step_n < 4) begin
      step_units[step_n] = u;
      step_n++;
    end
  endfunction

  // Append one byte to the held sequence, decode everything that is complete
  // and queue the resulting code units.
  function automatic void predict_units(input logic [7:0] b, input logic eos);
    logic [7:0]  lead;
    logic [20:0] cp;
    logic [20:0] ofs;
    int          ext;
    logic        bad;
    logic        stuck;
    unit_t       u;
    step_n = 0;
    if (held_cnt > 3) held_cnt = 3;
    held_bytes[held_cnt] = b;
    held_cnt++;
    stuck = 1'b0;
    while (held_cnt != 0 && !stuck) begin
      lead = held_bytes[0];
      casez (lead)
        8'b0???????: ext = 0;
        8'b110?????: ext = 1;
        8'b1110????: ext = 2;
        8'b11110???: ext = 3;
        default:     ext = -1;
      endcase
      if (ext == 0) begin
        keep_unit({8'h00, lead});
        drop_held(1);
      end else if (ext < 0) begin
        // stray continuation or F8-FF
        keep_unit(REPL_CHAR);
        drop_held(1);
      end else if (held_cnt < ext + 1) begin
        // sequence still open; end of string cuts it to one replacement
        if (eos) begin
          keep_unit(REPL_CHAR);
          held_cnt = 0;
        end
        stuck = 1'b1;
      end else begin
        cp = (ext == 1) ? {16'd0, lead[4:0]} :
             (ext == 2) ? {17'd0, lead[3:0]} : {18'd0, lead[2:0]};
        bad = 1'b0;
        for (int j = 1; j <= ext && !bad; j++) begin
          if (held_bytes[j][7:6] != 2'b10) bad = 1'b1;
          else cp = {cp[14:0], held_bytes[j][5:0]};
        end
        if (!bad)
          bad = (ext == 1 && cp < CP_MIN2) || (ext == 2 && cp < CP_MIN3) ||
                (ext == 3 && cp < SUPP_BASE) || cp > MAX_CP ||
                (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
        if (bad) begin
          // replace the lead only, rescan from the byte after it
          keep_unit(REPL_CHAR);
          drop_held(1);
        end else begin
          if (cp < SUPP_BASE) begin
            keep_unit(cp[15:0]);
          end else begin
            ofs = cp - SUPP_BASE;
            keep_unit(SURR_LO + {6'd0, ofs[19:10]});
            keep_unit(LOW_SURR_BASE + {6'd0, ofs[9:0]});
          end
          drop_held(ext + 1);
        end
      end
    end
    if (eos) held_cnt = 0;
    for (int k = 0; k < step_n; k++) begin
      u.code        = step_units[k];
      u.run_last    = (k == step_n - 1);
      u.string_last = u.run_last && eos;
      unit_q.insert(unit_q.size(), u);
    end
  endfunction

  // Driver: one transaction per handshake, random gaps between bytes except
  // in a quiet stretch every third block of 32 bytes and near the end.
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_units(in_byte, end_of_string);
        n_bytes_in++;
        nxt_valid = 1'b0;
        if (feed_q.size() >= 30 && (n_bytes_in / 32) % 3 != 2 && $urandom_range(0, 3) == 0)
          gap_cnt = $urandom_range(1, 10);
      end
      if (!nxt_valid) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (feed_q.size() != 0 && !(feed_q[0].drain && unit_q.size() != 0)) begin
          in_byte       <= feed_q[0].data;
          end_of_string <= feed_q[0].eos;
          nxt_valid     = 1'b1;
          void'(feed_q.pop_front());
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // Monitor: checks each output transaction and throttles out_ready. Once,
  // after 120 input bytes, the receiver holds off so that the decoder backs
  // up and drops in_ready.
  always @(posedge clk) begin
    logic  nxt_ready;
    unit_t want;
    nxt_ready = 1'b1;
    if (rst) begin
      nxt_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_units_out++;
        if (string_last === 1'b1) n_strings++;
        if (unit_q.size() == 0) begin
          report_mismatch("unit with nothing expected", '0);
        end else begin
          want = unit_q.pop_front();
          if (code_unit !== want.code || run_last !== want.run_last ||
              string_last !== want.string_last)
            report_mismatch("unit mismatch", want);
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        nxt_ready = 1'b0;
      end else if (!long_hold_done && n_bytes_in >= 120) begin
        long_hold_done = 1'b1;
        hold_cnt = 79;
        nxt_ready = 1'b0;
      end else if (feed_q.size() >= 30 && (n_units_out / 40) % 3 != 2 &&
                   $urandom_range(0, 4) == 0) begin
        hold_cnt = $urandom_range(0, 9);
        nxt_ready = 1'b0;
      end
    end
    out_ready <= nxt_ready;
  end

  task automatic add_byte(input logic [7:0] b, input logic eos, input logic drain = 1'b0);
    feed_t f;
    f.data  = b;
    f.eos   = eos;
    f.drain = drain;
    feed_q.insert(feed_q.size(), f);
  endtask

  initial begin
    logic [7:0]  str_bytes[$];
    logic [20:0] cp;
    int          rand_cnt;
    int          n_chars;
    int          pick;
    int          i;
    bit          drained;

    // Directed: field extremes, each sequence length, and each malformed form
    add_byte(8'h00, 1'b1);                                         // NUL as a string
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);                  // U+0080
    add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);  // U+FFFF
    add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0);                  // U+10FFFF, pair
    add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b1);
    add_byte(8'h80, 1'b0);                                         // stray continuation
    add_byte(8'hFF, 1'b0);                                         // never a lead
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'h41, 1'b0);  // bad 3rd byte
    add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);                  // overlong
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);  // surrogate
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0);                  // above U+10FFFF
    add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b1);                  // cut short, 41 dropped

    // Random strings: mostly well-formed text, some noise, corruption and
    // truncation; most strings close with end_of_string.
    rand_cnt = 0;
    drained  = 1'b0;
    while (rand_cnt < 190) begin
      str_bytes.delete();
      n_chars = $urandom_range(1, 8);
      for (i = 0; i < n_chars; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          cp = 21'($urandom_range(0, 'h7F));
        end else if (pick < 6) begin
          cp = 21'($urandom_range('h80, 'h7FF));
        end else if (pick < 8) begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp ^= 21'h002000;
        end else begin
          cp = 21'($urandom_range('h10000, 'h10FFFF));
        end
        if (pick == 9 && $urandom_range(0, 1) == 0) begin
          str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 255)));
        end else if (cp < CP_MIN2) begin
          str_bytes.insert(str_bytes.size(), cp[7:0]);
        end else if (cp < CP_MIN3) begin
          str_bytes.insert(str_bytes.size(), {3'b110, cp[10:6]});
          str_bytes.insert(str_bytes.size(), {2'b10, cp[5:0]});
        end else if (cp < SUPP_BASE) begin
          str_bytes.insert(str_bytes.size(), {4'b1110, cp[15:12]});
          str_bytes.insert(str_bytes.size(), {2'b10, cp[11:6]});
          str_bytes.insert(str_bytes.size(), {2'b10, cp[5:0]});
        end else begin
          str_bytes.insert(str_bytes.size(), {5'b11110, cp[20:18]});
          str_bytes.insert(str_bytes.size(), {2'b10, cp[17:12]});
          str_bytes.insert(str_bytes.size(), {2'b10, cp[11:6]});
          str_bytes.insert(str_bytes.size(), {2'b10, cp[5:0]});
        end
      end
      if ($urandom_range(0, 4) == 0)
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0 && str_bytes.size() > 1)
        void'(str_bytes.pop_back());
      for (i = 0; i < str_bytes.size(); i++)
        add_byte(str_bytes[i], i == str_bytes.size() - 1 && $urandom_range(0, 7) != 0,
                 i == 0 && !drained && rand_cnt >= 170);
      if (!drained && rand_cnt >= 170) drained = 1'b1;
      rand_cnt += str_bytes.size();
    end
    // close any sequence left open by the last random string
    add_byte(8'h7E, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || in_valid) @(posedge clk);
    while (unit_q.size() != 0) @(posedge clk);
    // catch any stray unit that trails the last expected one
    repeat (30) @(posedge clk);

    $display("tb: %0d bytes driven, %0d code units checked, %0d strings closed",
             n_bytes_in, n_units_out, n_strings);
    $display("tb: %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
